### rtl/rvx_pkg.sv
`default_nettype none
package rvx_pkg;

  // major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load funct3 with no instruction behind it
  localparam logic [2:0] F3_LD_NONE = 3'd7;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR   = 1;

  typedef enum logic [2:0] {
    CL_ALU, CL_LOAD, CL_STORE, CL_BRANCH, CL_LUI, CL_AUIPC, CL_JAL, CL_BAD
  } op_class_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] current_pc;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic               branch_taken;
    logic               write_enable;
    logic [4:0]         write_index;
    logic signed [63:0] write_value;
    logic [11:0]        mem_address;
    logic               illegal;
  } out_word_t;

  typedef struct packed {
    op_class_t   cls;
    logic [2:0]  f3;
    logic        alt;
    logic        use_imm;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] pc;
  } uop_t;

endpackage
`default_nettype wire

### rtl/rvx_front.sv
`default_nettype none
module rvx_front import rvx_pkg::*; (
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  input  wire logic     q_full,
  input  wire logic     clearing,
  output logic          q_push,
  output uop_t          q_data
);

  logic [31:0] ins;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;

  // classify and pull out the immediate
  always_comb begin
    ins = in_word.instr_word;
    opc = ins[6:0];
    f3  = ins[14:12];
    f7  = ins[31:25];
    q_data.cls     = CL_BAD;
    q_data.f3      = f3;
    q_data.alt     = 1'b0;
    q_data.use_imm = 1'b1;
    q_data.rd      = ins[11:7];
    q_data.rs1     = ins[19:15];
    q_data.rs2     = ins[24:20];
    q_data.imm     = {{20{ins[31]}}, ins[31:20]};
    q_data.pc      = in_word.current_pc;
    unique case (opc)
      OPC_OP: begin
        q_data.use_imm = 1'b0;
        q_data.alt     = (f7 == F7_ALT);
        if (f7 == F7_BASE || (f7 == F7_ALT && f3 == F3_ADD)) q_data.cls = CL_ALU;
      end
      OPC_OPIMM: begin
        if (!((f3 == F3_SLL || f3 == F3_SRL) && ins[31:26] != 6'd0)) q_data.cls = CL_ALU;
      end
      OPC_LOAD: begin
        if (f3 != F3_LD_NONE) q_data.cls = CL_LOAD;
      end
      OPC_STORE: begin
        q_data.imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        if (!f3[2]) q_data.cls = CL_STORE;
      end
      OPC_BRANCH: begin
        q_data.imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        if (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT || f3 == F3_BGE ||
            f3 == F3_BLTU || f3 == F3_BGEU) q_data.cls = CL_BRANCH;
      end
      OPC_LUI: begin
        q_data.imm = {ins[31:12], 12'd0};
        q_data.cls = CL_LUI;
      end
      OPC_AUIPC: begin
        q_data.imm = {ins[31:12], 12'd0};
        q_data.cls = CL_AUIPC;
      end
      OPC_JAL: begin
        q_data.imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        q_data.cls = CL_JAL;
      end
      default: q_data.cls = CL_BAD;
    endcase
  end

  assign in_stall = q_full | clearing;
  assign q_push   = in_valid & ~in_stall;

endmodule
`default_nettype wire

### rtl/rvx_queue.sv
`default_nettype none
module rvx_queue import rvx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire uop_t push_data,
  input  wire logic pop,
  output uop_t      head,
  output logic      empty,
  output logic      full
);

  uop_t            ent_r [QDEPTH];
  logic [QPTR-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR+1)'(push) - (QPTR+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

  assign head  = ent_r[rp_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QPTR+1)'(QDEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

### rtl/rvx_back.sv
`default_nettype none
module rvx_back import rvx_pkg::*; #(
  parameter int DATA_BYTES = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire uop_t q_head,
  input  wire logic q_empty,
  output logic      q_pop,
  output logic      clearing,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word
);

  localparam int AW = $clog2(DATA_BYTES);
  localparam bit POW2 = ((64'd1 << AW) == 64'(DATA_BYTES));
  // folded address is below 2^18 * DATA_BYTES
  localparam int SW = AW + 18;
  localparam logic [AW-1:0] C1 = AW'((64'd1 << 16) % 64'(DATA_BYTES));
  localparam logic [AW-1:0] C2 = AW'((64'd1 << 32) % 64'(DATA_BYTES));
  localparam logic [AW-1:0] C3 = AW'((64'd1 << 48) % 64'(DATA_BYTES));

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_MOD  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_LAST = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  uop_t        cur_r;
  logic [63:0] rf [32];
  logic [31:0] rf_valid_r;
  logic [63:0] rs1_ram_r, rs2_ram_r;
  logic        rs1_v_r, rs2_v_r;
  logic        fwd_en_r;
  logic [4:0]  fwd_idx_r;
  logic [63:0] fwd_val_r;

  out_word_t   res_r, exec_res, mem_res;
  logic        out_valid_r;
  out_word_t   out_word_r;

  logic [7:0]    dmem [DATA_BYTES];
  logic [AW-1:0] clr_r, addr_r, base_r;
  logic [63:0]   ea_r;
  logic [SW-1:0] red_r, red_nxt, red_sub;
  logic [AW+15:0] prod1, prod2, prod3;
  logic [5:0]    mcnt_r;
  logic [2:0]    bcnt_r, blast;
  logic [63:0]   ldval_r, bval_r, ld_all, ld_ext;
  logic          rdpend_r;
  logic [2:0]    rdidx_r;
  logic [7:0]    rdata_r;

  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [7:0]    dm_wdata;

  logic [63:0] a, b, opb, imm64, alu_v, ea;
  logic [31:0] pc4, tgt;
  logic        br;
  logic        slot_free, deliver, is_mem;

  // operands: forward the write that lands on the same edge as the read
  always_comb begin
    a = (fwd_en_r && fwd_idx_r == cur_r.rs1) ? fwd_val_r : (rs1_v_r ? rs1_ram_r : 64'd0);
    b = (fwd_en_r && fwd_idx_r == cur_r.rs2) ? fwd_val_r : (rs2_v_r ? rs2_ram_r : 64'd0);
    imm64 = {{32{cur_r.imm[31]}}, cur_r.imm};
    opb   = cur_r.use_imm ? imm64 : b;
    ea    = a + imm64;
    pc4   = cur_r.pc + 32'd4;
    tgt   = cur_r.pc + cur_r.imm;
    case (cur_r.f3)
      F3_ADD:  alu_v = cur_r.alt ? a - opb : a + opb;
      F3_SLL:  alu_v = a << opb[5:0];
      F3_SLT:  alu_v = {63'd0, $signed(a) < $signed(opb)};
      F3_SLTU: alu_v = {63'd0, a < opb};
      F3_XOR:  alu_v = a ^ opb;
      F3_SRL:  alu_v = a >> opb[5:0];
      F3_OR:   alu_v = a | opb;
      default: alu_v = a & opb;
    endcase
    case (cur_r.f3)
      F3_BEQ:  br = (a == b);
      F3_BNE:  br = (a != b);
      F3_BLT:  br = ($signed(a) < $signed(b));
      F3_BGE:  br = !($signed(a) < $signed(b));
      F3_BLTU: br = (a < b);
      F3_BGEU: br = (a >= b);
      default: br = 1'b0;
    endcase
    is_mem = (cur_r.cls == CL_LOAD) || (cur_r.cls == CL_STORE);
  end

  always_comb begin
    exec_res = '0;
    exec_res.next_pc = pc4;
    case (cur_r.cls)
      CL_ALU: begin
        exec_res.write_enable = 1'b1;
        exec_res.write_value  = alu_v;
      end
      CL_BRANCH: begin
        exec_res.branch_taken = br;
        if (br) exec_res.next_pc = tgt;
      end
      CL_LUI: begin
        exec_res.write_enable = 1'b1;
        exec_res.write_value  = imm64;
      end
      CL_AUIPC: begin
        exec_res.write_enable = 1'b1;
        exec_res.write_value  = imm64 + {32'd0, cur_r.pc};
      end
      CL_JAL: begin
        exec_res.write_enable = 1'b1;
        exec_res.write_value  = {32'd0, pc4};
        exec_res.branch_taken = 1'b1;
        exec_res.next_pc      = tgt;
      end
      CL_BAD:  exec_res.illegal = 1'b1;
      default: exec_res.illegal = 1'b0;
    endcase
    if (cur_r.rd == 5'd0) exec_res.write_enable = 1'b0;
    if (exec_res.write_enable) begin
      exec_res.write_index = cur_r.rd;
    end else begin
      exec_res.write_value = '0;
    end
  end

  // load/store completion: merge the last byte, extend by size
  always_comb begin
    ld_all = ldval_r;
    if (rdpend_r) ld_all[8*rdidx_r +: 8] = rdata_r;
    case (cur_r.f3)
      3'd0:    ld_ext = {{56{ld_all[7]}}, ld_all[7:0]};
      3'd1:    ld_ext = {{48{ld_all[15]}}, ld_all[15:0]};
      3'd2:    ld_ext = {{32{ld_all[31]}}, ld_all[31:0]};
      3'd4:    ld_ext = {56'd0, ld_all[7:0]};
      3'd5:    ld_ext = {48'd0, ld_all[15:0]};
      3'd6:    ld_ext = {32'd0, ld_all[31:0]};
      default: ld_ext = ld_all;
    endcase
    mem_res = '0;
    mem_res.next_pc     = pc4;
    mem_res.mem_address = 12'(base_r);
    if (cur_r.cls == CL_LOAD && cur_r.rd != 5'd0) begin
      mem_res.write_enable = 1'b1;
      mem_res.write_index  = cur_r.rd;
      mem_res.write_value  = ld_ext;
    end
  end

  // address reduction: first fold the 16-bit chunks with their weights mod
  // DATA_BYTES, then strip shifted copies of DATA_BYTES, three per cycle
  always_comb begin
    int sh;
    prod1   = ea_r[31:16] * C1;
    prod2   = ea_r[47:32] * C2;
    prod3   = ea_r[63:48] * C3;
    red_sub = red_r;
    for (int s = 0; s < 3; s++) begin
      sh = 20 - 3 * int'(mcnt_r) - s;
      if (red_sub >= (SW'(DATA_BYTES) << sh)) red_sub = red_sub - (SW'(DATA_BYTES) << sh);
    end
    red_nxt = (mcnt_r == 6'd0) ? SW'(ea_r[15:0]) + SW'(prod1) + SW'(prod2) + SW'(prod3)
                               : red_sub;
  end

  assign blast     = 3'((4'd1 << cur_r.f3[1:0]) - 4'd1);
  assign slot_free = !out_valid_r || !out_stall;
  assign deliver   = (state_r == S_DONE) && slot_free;
  assign q_pop     = ((state_r == S_IDLE) || deliver) && !q_empty;
  assign clearing  = (state_r == S_CLR);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == AW'(DATA_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (!q_empty) state_nxt = S_EXEC;
      S_EXEC: begin
        if (!is_mem) state_nxt = S_DONE;
        else if (POW2) state_nxt = S_ACC;
        else state_nxt = S_MOD;
      end
      S_MOD:  if (mcnt_r == 6'd6) state_nxt = S_ACC;
      S_ACC:  if (bcnt_r == blast) state_nxt = S_LAST;
      S_LAST: state_nxt = S_DONE;
      S_DONE: if (slot_free) state_nxt = q_empty ? S_IDLE : S_EXEC;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      rf_valid_r  <= '0;
      fwd_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rdpend_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rdpend_r <= (state_r == S_ACC) && (cur_r.cls == CL_LOAD);
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (deliver) begin
        out_valid_r <= 1'b1;
        fwd_en_r    <= res_r.write_enable;
        if (res_r.write_enable) rf_valid_r[res_r.write_index] <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rdidx_r <= bcnt_r;
    if (q_pop) begin
      cur_r     <= q_head;
      rs1_ram_r <= rf[q_head.rs1];
      rs2_ram_r <= rf[q_head.rs2];
      rs1_v_r   <= rf_valid_r[q_head.rs1];
      rs2_v_r   <= rf_valid_r[q_head.rs2];
    end
    if (deliver) begin
      out_word_r <= res_r;
      fwd_idx_r  <= res_r.write_index;
      fwd_val_r  <= res_r.write_value;
      if (res_r.write_enable) rf[res_r.write_index] <= res_r.write_value;
    end
    if (state_r == S_EXEC) begin
      res_r   <= exec_res;
      ea_r    <= ea;
      mcnt_r  <= '0;
      bcnt_r  <= '0;
      ldval_r <= '0;
      bval_r  <= b;
      addr_r  <= ea[AW-1:0];
      base_r  <= ea[AW-1:0];
    end
    if (state_r == S_MOD) begin
      red_r  <= red_nxt;
      mcnt_r <= mcnt_r + 1'b1;
      addr_r <= red_nxt[AW-1:0];
      base_r <= red_nxt[AW-1:0];
    end
    if (state_r == S_ACC) begin
      bcnt_r <= bcnt_r + 1'b1;
      addr_r <= (addr_r == AW'(DATA_BYTES - 1)) ? '0 : addr_r + 1'b1;
    end
    if (rdpend_r) ldval_r[8*rdidx_r +: 8] <= rdata_r;
    if (state_r == S_LAST) res_r <= mem_res;
  end

  // byte memory: one write port, one registered read port
  always_comb begin
    dm_we    = (state_r == S_CLR) || ((state_r == S_ACC) && (cur_r.cls == CL_STORE));
    dm_waddr = (state_r == S_CLR) ? clr_r : addr_r;
    dm_wdata = (state_r == S_CLR) ? 8'd0 : bval_r[8*bcnt_r +: 8];
  end

  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    rdata_r <= dmem[addr_r];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (deliver && res_r.write_enable) |-> (res_r.write_index != 5'd0))
    else $error("write to x0");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("instruction taken during memory clear");
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (deliver && res_r.illegal) |-> (!res_r.write_enable && !res_r.branch_taken))
    else $error("illegal instruction changed state");

endmodule
`default_nettype wire

### rtl/rv64_integer_execute_top.sv
// Flow: a word leaves the queue with its register file read, then executes; ALU, branch,
// lui, auipc and jal words then reach out_word. Loads and stores first reduce the address
// when DATA_BYTES is not a power of two (chunk fold, then compare-subtract), then
// move one byte at a time through the data memory before they reach out_word.
// The next word leaves the queue only as the previous one is delivered to out_word.
// Reset: synchronous, active low; afterwards the data memory is cleared with in_stall
// high, and the register file reads as zero until written.
`default_nettype none
module rv64_integer_execute_top import rvx_pkg::*; #(
  parameter int DATA_BYTES = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  // front to queue
  logic q_push, q_full, q_empty, q_pop, clearing;
  uop_t q_data, q_head;

  // decode and accept; hold off while the memory clears
  rvx_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // short queue so front and back stall on their own
  rvx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // execute against the register file and data memory
  rvx_back #(
    .DATA_BYTES (DATA_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

### tb/tb_rv64_integer_execute_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_rv64_integer_execute_top;
  import rvx_pkg::*;

  localparam int MEM_BYTES = 4096;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  rv64_integer_execute_top #(.DATA_BYTES(MEM_BYTES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow architectural state, updated as each word is accepted.
  logic [63:0] shadow_regs [32];
  logic [7:0]  shadow_mem  [MEM_BYTES];

  out_word_t pending_results [$];
  int        mismatch_count;

  function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
    logic [63:0] m;
    m = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    v = v & m;
    if (bits < 64 && v[bits-1]) v = v | ~m;
    return v;
  endfunction

  function automatic logic [63:0] alu_result(input logic [2:0] f3, input logic [63:0] a,
                                             input logic [63:0] b, input logic alt);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[5:0];
      F3_SLT:  return ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      F3_SLTU: return (a < b) ? 64'd1 : 64'd0;
      F3_XOR:  return a ^ b;
      F3_SRL:  return a >> b[5:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Execute one word against the shadow state and return what the block must produce.
  function automatic out_word_t execute_word(input in_word_t w);
    out_word_t r;
    logic [31:0] ins, pc, nxt, off;
    logic [6:0]  opc, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [63:0] a, b, immi, val;
    logic [11:0] maddr;
    logic        taken, wr, bad;
    int          n;
    ins = w.instr_word; pc = w.current_pc;
    opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
    a = (ins[19:15] == 0) ? 64'd0 : shadow_regs[ins[19:15]];
    b = (ins[24:20] == 0) ? 64'd0 : shadow_regs[ins[24:20]];
    immi = sx({52'd0, ins[31:20]}, 12);
    nxt = pc + 32'd4; taken = 0; wr = 0; bad = 0; val = 0; maddr = 0;
    case (opc)
      OPC_OP: begin
        if (f7 == F7_BASE || (f7 == F7_ALT && f3 == F3_ADD)) begin
          val = alu_result(f3, a, b, f7 == F7_ALT); wr = 1;
        end else bad = 1;
      end
      OPC_OPIMM: begin
        if ((f3 == F3_SLL || f3 == F3_SRL) && ins[31:26] != 0) bad = 1;
        else begin
          val = alu_result(f3, a, immi, 1'b0); wr = 1;
        end
      end
      OPC_LOAD: begin
        if (f3 == F3_LD_NONE) bad = 1;
        else begin
          maddr = 12'((a + immi) % MEM_BYTES);
          n = 1 << f3[1:0];
          for (int i = 0; i < n; i++)
            val[8*i +: 8] = shadow_mem[(int'(maddr) + i) % MEM_BYTES];
          if (!f3[2] && n < 8) val = sx(val, 8 * n);
          wr = 1;
        end
      end
      OPC_STORE: begin
        if (f3[2]) bad = 1;
        else begin
          maddr = 12'((a + sx({52'd0, ins[31:25], rd}, 12)) % MEM_BYTES);
          n = 1 << f3[1:0];
          for (int i = 0; i < n; i++)
            shadow_mem[(int'(maddr) + i) % MEM_BYTES] = b[8*i +: 8];
        end
      end
      OPC_BRANCH: begin
        off = {19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        case (f3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = $signed(a) < $signed(b);
          F3_BGE:  taken = $signed(a) >= $signed(b);
          F3_BLTU: taken = a < b;
          F3_BGEU: taken = a >= b;
          default: bad = 1;
        endcase
        if (taken) nxt = pc + 32'(sx({32'd0, off}, 13));
      end
      OPC_LUI: begin
        val = sx({32'd0, ins & 32'hFFFFF000}, 32); wr = 1;
      end
      OPC_AUIPC: begin
        val = sx({32'd0, ins & 32'hFFFFF000}, 32) + {32'd0, pc}; wr = 1;
      end
      OPC_JAL: begin
        off = {11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        val = {32'd0, pc + 32'd4}; wr = 1; taken = 1;
        nxt = pc + 32'(sx({32'd0, off}, 21));
      end
      default: bad = 1;
    endcase
    if (bad) begin
      wr = 0; taken = 0; maddr = 0; nxt = pc + 32'd4;
    end
    if (wr && rd != 0) shadow_regs[rd] = val;
    else wr = 0;
    r.next_pc = nxt;
    r.branch_taken = taken;
    r.write_enable = wr;
    r.write_index = wr ? rd : 5'd0;
    r.write_value = wr ? val : 64'd0;
    r.mem_address = maddr;
    r.illegal = bad;
    return r;
  endfunction

  // Directed rows: a fixed expectation is typed in only where it is obvious.
  typedef struct {
    logic [31:0] ins;
    logic [31:0] pc;
    logic        fixed;
    out_word_t   want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic out_word_t plain(input logic [31:0] nxt, input logic il);
    out_word_t r;
    r = '0; r.next_pc = nxt; r.illegal = il;
    return r;
  endfunction

  function automatic dir_row_t row(input logic [31:0] ins, input logic [31:0] pc);
    dir_row_t d;
    d.ins = ins; d.pc = pc; d.fixed = 0; d.want = '0;
    return d;
  endfunction

  function automatic dir_row_t row_fixed(input logic [31:0] ins, input logic [31:0] pc,
                                         input out_word_t w);
    dir_row_t d;
    d.ins = ins; d.pc = pc; d.fixed = 1; d.want = w;
    return d;
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
      input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] off, input logic [4:0] rd);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  // Random instruction, mostly well-formed; registers mostly from a small pool so data flows.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] pick_imm12_addr();
    // keep most accesses inside a small window so stores are read back
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 63)) - 32'd16;
  endfunction

  function automatic logic [31:0] random_instr();
    logic [2:0] f3;
    int k;
    f3 = 3'($urandom);
    k = $urandom_range(0, 99);
    if (k < 8) return $urandom;                       // noise, mostly illegal
    if (k < 25) return enc_r(($urandom_range(0, 3) == 0 && f3 == F3_ADD) ? F7_ALT : F7_BASE,
                             pick_reg(), pick_reg(), f3, pick_reg(), OPC_OP);
    if (k < 27) return enc_r(7'($urandom), pick_reg(), pick_reg(), f3, pick_reg(), OPC_OP);
    if (k < 45) begin
      if (f3 == F3_SLL || f3 == F3_SRL)
        return enc_i({($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'd0, 6'($urandom)},
                     pick_reg(), f3, pick_reg(), OPC_OPIMM);
      return enc_i(12'($urandom), pick_reg(), f3, pick_reg(), OPC_OPIMM);
    end
    if (k < 60) return enc_i(12'(pick_imm12_addr()), pick_reg(),
                             ($urandom_range(0, 15) == 0) ? F3_LD_NONE : 3'($urandom_range(0, 6)),
                             pick_reg(), OPC_LOAD);
    if (k < 75) return enc_s(12'(pick_imm12_addr()), pick_reg(), pick_reg(),
                             ($urandom_range(0, 15) == 0) ? 3'($urandom_range(4, 7))
                                                          : 3'($urandom_range(0, 3)));
    if (k < 87) return enc_b(13'($urandom), pick_reg(), pick_reg(), f3);
    if (k < 91) return {20'($urandom), pick_reg(), OPC_LUI};
    if (k < 95) return {20'($urandom), pick_reg(), OPC_AUIPC};
    return enc_j(21'($urandom), pick_reg());
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stall, compare each accepted word with the oldest expectation.
  logic quiet_out;
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    quiet_out = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_out) out_stall <= 1'b0;
      else if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        hold = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word: %p", out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word.next_pc !== want.next_pc || out_word.branch_taken !== want.branch_taken ||
            out_word.write_enable !== want.write_enable ||
            out_word.write_index !== want.write_index ||
            out_word.write_value !== want.write_value ||
            out_word.mem_address !== want.mem_address || out_word.illegal !== want.illegal) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p got %p", want, out_word);
        end
      end
    end
  end

  // Send one word: hold it until accepted, then predict on acceptance.
  task automatic send_word(input logic [31:0] ins, input logic [31:0] pc,
                           input logic fixed, input out_word_t want);
    out_word_t got;
    in_word.instr_word <= ins;
    in_word.current_pc <= pc;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    got = execute_word('{instr_word: ins, current_pc: pc});
    if (fixed && got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("table row disagrees: %p vs %p", want, got);
    end
    pending_results.push_back(fixed ? want : got);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    in_word <= in_word_t'({$urandom, $urandom});
    repeat (n) @(negedge clk);
  endtask

  initial begin
    out_word_t w;
    logic [31:0] pc;
    int g;
    mismatch_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed table: after reset, illegal forms, x0 destination, extremes, every op.
    dir_rows.push_back(row_fixed(enc_i(12'd0, 5'd0, F3_LD_NONE - 3'd4, 5'd1, OPC_LOAD),
                                 32'd0, '{next_pc: 32'd4, write_enable: 1'b1,
                                          write_index: 5'd1, default: '0}));
    dir_rows.push_back(row_fixed(32'hFFFF_FFFF, 32'hFFFF_FFFC, plain(32'd0, 1'b1)));
    dir_rows.push_back(row_fixed(32'h0000_0000, 32'h0000_0100, plain(32'h104, 1'b1)));
    dir_rows.push_back(row_fixed(enc_r(7'h01, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP),
                                 32'd8, plain(32'd12, 1'b1)));
    dir_rows.push_back(row_fixed(enc_r(F7_ALT, 5'd2, 5'd1, F3_SRL, 5'd3, OPC_OP),
                                 32'd8, plain(32'd12, 1'b1)));
    dir_rows.push_back(row_fixed(enc_i({F7_ALT[5:0], 6'd3}, 5'd1, F3_SRL, 5'd3, OPC_OPIMM),
                                 32'd8, plain(32'd12, 1'b1)));
    dir_rows.push_back(row_fixed(enc_i(12'd0, 5'd1, F3_LD_NONE, 5'd3, OPC_LOAD),
                                 32'd8, plain(32'd12, 1'b1)));
    dir_rows.push_back(row_fixed(enc_s(12'd0, 5'd1, 5'd1, 3'd4), 32'd8, plain(32'd12, 1'b1)));
    dir_rows.push_back(row_fixed(enc_b(13'd16, 5'd1, 5'd1, 3'd2), 32'd8, plain(32'd12, 1'b1)));
    dir_rows.push_back(row_fixed(32'h0000_003B, 32'd8, plain(32'd12, 1'b1)));
    dir_rows.push_back(row_fixed(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd0, OPC_OPIMM),
                                 32'd0, plain(32'd4, 1'b0)));
    dir_rows.push_back(row(enc_i(12'h800, 5'd0, F3_ADD, 5'd1, OPC_OPIMM), 32'd0));
    dir_rows.push_back(row(32'h8000_00B7, 32'd0));                    // lui x1, sign bit
    dir_rows.push_back(row(32'hFFFF_F117, 32'hFFFF_FFFC));            // auipc, pc extreme
    dir_rows.push_back(row(enc_r(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd4, OPC_OP), 32'd0));
    dir_rows.push_back(row(enc_r(F7_BASE, 5'd1, 5'd1, F3_SLL, 5'd5, OPC_OP), 32'd0));
    dir_rows.push_back(row(enc_i(12'h03F, 5'd1, F3_SRL, 5'd6, OPC_OPIMM), 32'd0));
    dir_rows.push_back(row(enc_s(12'hFFF, 5'd1, 5'd0, 3'd3), 32'd0)); // sd wraps at top
    dir_rows.push_back(row(enc_i(12'hFFD, 5'd0, 3'd3, 5'd7, OPC_LOAD), 32'd0));
    dir_rows.push_back(row(enc_i(12'hFFF, 5'd0, 3'd4, 5'd8, OPC_LOAD), 32'd0));
    dir_rows.push_back(row(enc_i(12'hFFF, 5'd0, 3'd0, 5'd9, OPC_LOAD), 32'd0));
    dir_rows.push_back(row(enc_b(13'h1000, 5'd1, 5'd4, F3_BGE), 32'd0));
    dir_rows.push_back(row(enc_b(13'h0FFE, 5'd1, 5'd1, F3_BGEU), 32'd0));
    dir_rows.push_back(row(enc_j(21'h100000, 5'd1), 32'hFFFF_FFFC));
    dir_rows.push_back(row(enc_j(21'h0FFFFE, 5'd0), 32'd0));

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].ins, dir_rows[i].pc, dir_rows[i].fixed, dir_rows[i].want);
      if (gap_len() > 0) idle_sender($urandom_range(1, 3));
    end

    // Random part; once midway, drain completely before sending on.
    pc = '0;
    w = '0;
    for (int n = 0; n < 1950; n++) begin
      if (n == 900) begin
        idle_sender(1);
        while (pending_results.size() != 0) @(negedge clk);
      end
      pc = ($urandom_range(0, 9) == 0) ? $urandom : pc + 32'd4;
      // runs of back-to-back words with no gaps for words 601 to 799
      if (n > 600 && n < 800) send_word(random_instr(), pc, 1'b0, w);
      else begin
        send_word(random_instr(), pc, 1'b0, w);
        g = gap_len();
        if (g > 0) idle_sender(g);
      end
    end
    idle_sender(0);

    quiet_out = 1'b1;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
